// ----- design/gdi_pkg.sv -----
package gdi_pkg;

   // field widths of the stream words
   localparam int COUNT_W = 16;
   localparam int VALUE_W = 32;
   localparam int CW_W = 31;
   localparam int DEC_W = 4;
   localparam int RSP_DATA_W = 40;

   // default histogram size and fixed-point format
   localparam int MAX_CLASSES_DEF = 64;
   localparam int FRAC_BITS = 8;
   localparam logic [CW_W-1:0] CW_RESET = CW_W'(1) << FRAC_BITS;

   // decile numbering
   localparam logic [DEC_W-1:0] FIRST_DECILE = 4'd1;
   localparam logic [DEC_W-1:0] LAST_DECILE = 4'd9;

   // register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LOWER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS_WIDTH = 1'd1;

   // width of the divider step counter (one quotient bit per step)
   localparam int STEP_W = $clog2(CW_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CMP,
      ST_DIV,
      ST_OUT
   } gdi_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_MUL,
      DV_STEP
   } gdi_div_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gdi_div_status_type;

endpackage

// ----- design/gdi_ram.sv -----
module gdi_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gdi_div.sv -----
module gdi_div #(
   parameter int NUM_W = 26
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            num,
   input  logic [NUM_W-1:0]            divisor,
   input  logic [gdi_pkg::CW_W-1:0]    mult,
   output gdi_pkg::gdi_div_status_type status,
   output logic [gdi_pkg::CW_W-1:0]    quotient
);

   localparam int QW = gdi_pkg::CW_W;
   localparam int PW = NUM_W + QW;

   gdi_pkg::gdi_div_state_type state_ff, state_in;
   logic [NUM_W-1:0]            num_ff, num_in;
   logic [QW-1:0]               mult_ff, mult_in;
   logic [NUM_W-1:0]            div_ff, div_in;
   logic [NUM_W-1:0]            rem_ff, rem_in;
   logic [QW-1:0]               shf_ff, shf_in;
   logic [gdi_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        done_ff, done_in;

   logic [PW-1:0]    prod;
   logic [NUM_W:0]   trial;
   logic [NUM_W:0]   diff;
   logic             ge;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdi_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // operand and remainder registers
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      mult_ff <= mult_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      shf_ff  <= shf_in;
      step_ff <= step_in;
   end

   // product once, then one restoring step per cycle
   assign prod  = PW'(num_ff) * PW'(mult_ff);
   assign trial = {rem_ff, shf_ff[QW-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      mult_in  = mult_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      shf_in   = shf_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         gdi_pkg::DV_IDLE: begin
            if (start) begin
               num_in   = num;
               mult_in  = mult;
               div_in   = divisor;
               state_in = gdi_pkg::DV_MUL;
            end
         end
         gdi_pkg::DV_MUL: begin
            // upper product bits are already below the divisor
            rem_in   = prod[PW-1:QW];
            shf_in   = prod[QW-1:0];
            step_in  = '0;
            state_in = gdi_pkg::DV_STEP;
         end
         gdi_pkg::DV_STEP: begin
            rem_in  = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            shf_in  = {shf_ff[QW-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == gdi_pkg::STEP_W'(QW - 1)) begin
               done_in  = 1'b1;
               state_in = gdi_pkg::DV_IDLE;
            end
         end
         default: state_in = gdi_pkg::DV_IDLE;
      endcase
   end

   assign status.busy = (state_ff != gdi_pkg::DV_IDLE);
   assign status.done = done_ff;
   assign quotient    = shf_ff;

endmodule

// ----- design/grouped_decile_interpolator_top.sv -----
// class word that is not the last: taken with no result.
// last class word: per decile, a fetch and a compare for each class scanned, then the shared
// multiply / shift-subtract divider, then the result word; the divider yields one quotient
// bit per cycle. zero total: 9 result words.
// no new class word is taken until the ninth result word is taken.
// reset (synchronous, active high) empties the histogram and loads register defaults.
module grouped_decile_interpolator_top #(
   parameter int MAX_CLASSES = gdi_pkg::MAX_CLASSES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // class word
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gdi_pkg::COUNT_W-1:0]      req_tdata,   // [15:0] class_count_value
   input  logic                             req_tlast,   // final_class
   // decile word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gdi_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [3:0] decile_index, [35:4] decile_value
   output logic                             rsp_tuser,   // empty_error
   output logic                             rsp_tlast,   // run_end
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gdi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gdi_pkg::VALUE_W-1:0]      csr_data
);

   localparam int AW     = $clog2(MAX_CLASSES);
   localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
   localparam int CF_W   = gdi_pkg::COUNT_W + $clog2(MAX_CLASSES);
   localparam int TGT_W  = CF_W + 4;
   localparam int BASE_W = gdi_pkg::VALUE_W + 2 + AW;
   localparam int VW     = gdi_pkg::VALUE_W;
   localparam int CW_W   = gdi_pkg::CW_W;

   gdi_pkg::gdi_state_type state_ff, state_in;

   logic [VW-1:0]                flb_ff, flb_in;
   logic [CW_W-1:0]              cw_ff, cw_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CF_W-1:0]              cf_run_ff, cf_run_in;
   logic [CF_W-1:0]              total_ff, total_in;
   logic [TGT_W-1:0]             target_ff, target_in;
   logic [CF_W-1:0]              prev_ff, prev_in;
   logic [AW-1:0]                j_ff, j_in;
   logic [BASE_W-1:0]            base_ff, base_in;
   logic [gdi_pkg::DEC_W-1:0]    i_ff, i_in;
   logic                         err_ff, err_in;
   logic [VW-1:0]                val_ff, val_in;

   logic                         wr_en;
   logic [CF_W-1:0]              new_cf;
   logic                         room;
   logic [CF_W-1:0]              rd_cf;
   logic [TGT_W-1:0]             cf10;
   logic [TGT_W-1:0]             prev10;
   logic                         div_start;
   gdi_pkg::gdi_div_status_type  div_stat;
   logic [CW_W-1:0]              quot;
   logic [BASE_W-1:0]            sum;
   logic [BASE_W-VW:0]           sum_hi;

   // cumulative counts
   gdi_ram #(
      .WIDTH (CF_W),
      .DEPTH (MAX_CLASSES)
   ) u_totals (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (new_cf),
      .rd_addr (j_ff),
      .rd_data (rd_cf)
   );

   // shared multiply and divide unit
   gdi_div #(
      .NUM_W (TGT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (target_ff - prev10),
      .divisor  (cf10 - prev10),
      .mult     (cw_ff),
      .status   (div_stat),
      .quotient (quot)
   );

   // control and register state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gdi_pkg::ST_IDLE;
         flb_ff    <= '0;
         cw_ff     <= gdi_pkg::CW_RESET;
         cnt_ff    <= '0;
         cf_run_ff <= '0;
      end else begin
         state_ff  <= state_in;
         flb_ff    <= flb_in;
         cw_ff     <= cw_in;
         cnt_ff    <= cnt_in;
         cf_run_ff <= cf_run_in;
      end
   end

   // search and result registers
   always_ff @(posedge clock) begin
      total_ff  <= total_in;
      target_ff <= target_in;
      prev_ff   <= prev_in;
      j_ff      <= j_in;
      base_ff   <= base_in;
      i_ff      <= i_in;
      err_ff    <= err_in;
      val_ff    <= val_in;
   end

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      flb_in = flb_ff;
      cw_in  = cw_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gdi_pkg::REG_FIRST_LOWER: flb_in = csr_data;
            gdi_pkg::REG_CLASS_WIDTH: cw_in  = csr_data[CW_W-1:0];
         endcase
      end
   end

   // times ten as two shifts
   assign cf10   = (TGT_W'(rd_cf) << 3) + (TGT_W'(rd_cf) << 1);
   assign prev10 = (TGT_W'(prev_ff) << 3) + (TGT_W'(prev_ff) << 1);

   assign room   = (cnt_ff < CNT_W'(MAX_CLASSES));
   assign new_cf = cf_run_ff + CF_W'(req_tdata);

   // decile value with saturation to 32 bits
   assign sum    = base_ff + BASE_W'(quot);
   assign sum_hi = sum[BASE_W-1:VW-1];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cf_run_in = cf_run_ff;
      total_in  = total_ff;
      target_in = target_ff;
      prev_in   = prev_ff;
      j_in      = j_ff;
      base_in   = base_ff;
      i_in      = i_ff;
      err_in    = err_ff;
      val_in    = val_ff;
      wr_en     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         gdi_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // store running count while there is room
               if (room) begin
                  wr_en     = 1'b1;
                  cf_run_in = new_cf;
                  cnt_in    = cnt_ff + 1'b1;
               end
               if (req_tlast) begin
                  total_in  = room ? new_cf : cf_run_ff;
                  target_in = room ? TGT_W'(new_cf) : TGT_W'(cf_run_ff);
                  cf_run_in = '0;
                  cnt_in    = '0;
                  prev_in   = '0;
                  j_in      = '0;
                  base_in   = {{(BASE_W-VW){flb_ff[VW-1]}}, flb_ff};
                  i_in      = gdi_pkg::FIRST_DECILE;
                  val_in    = '0;
                  err_in    = (target_in == '0);
                  state_in  = err_in ? gdi_pkg::ST_OUT : gdi_pkg::ST_FETCH;
               end
            end
         end
         gdi_pkg::ST_FETCH: begin
            state_in = gdi_pkg::ST_CMP;
         end
         gdi_pkg::ST_CMP: begin
            if (cf10 >= target_ff) begin
               div_start = 1'b1;
               state_in  = gdi_pkg::ST_DIV;
            end else begin
               prev_in  = rd_cf;
               j_in     = j_ff + 1'b1;
               base_in  = base_ff + BASE_W'(cw_ff);
               state_in = gdi_pkg::ST_FETCH;
            end
         end
         gdi_pkg::ST_DIV: begin
            if (div_stat.done) begin
               if ((&sum_hi) || !(|sum_hi)) begin
                  val_in = sum[VW-1:0];
               end else if (sum[BASE_W-1]) begin
                  val_in = {1'b1, {(VW-1){1'b0}}};
               end else begin
                  val_in = {1'b0, {(VW-1){1'b1}}};
               end
               state_in = gdi_pkg::ST_OUT;
            end
         end
         gdi_pkg::ST_OUT: begin
            if (rsp_tready) begin
               if (i_ff == gdi_pkg::LAST_DECILE) begin
                  state_in = gdi_pkg::ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  if (!err_ff) begin
                     // same class may hold the next decile too
                     target_in = target_ff + TGT_W'(total_ff);
                     state_in  = gdi_pkg::ST_FETCH;
                  end
               end
            end
         end
         default: state_in = gdi_pkg::ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == gdi_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == gdi_pkg::ST_OUT);
   assign rsp_tdata  = {{(gdi_pkg::RSP_DATA_W-VW-gdi_pkg::DEC_W){1'b0}}, val_ff, i_ff};
   assign rsp_tuser  = err_ff;
   assign rsp_tlast  = (i_ff == gdi_pkg::LAST_DECILE);

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("class word taken while decile word pending");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (val_ff == '0))
      else $error("empty histogram with nonzero decile value");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_CLASSES))
      else $error("class count beyond capacity");

endmodule
